FILE: rtl/core/integer_to_text_formatter_defines.svh
// Assertion macros for the integer-to-text formatter checker.
`ifndef INTEGER_TO_TEXT_FORMATTER_DEFINES_SVH
`define INTEGER_TO_TEXT_FORMATTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ITF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ITF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/itf_pkg.sv
// Shared constants, types and character helpers of the integer-to-text formatter.
package itf_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_FIELD  = 60;
  localparam int FIELD_W    = 6;
  localparam int DIGIT_W    = 4;
  // Binary gives the most digits: one per value bit.
  localparam int MAX_DIGITS = VALUE_BITS;
  localparam int NDIG_W     = $clog2(MAX_DIGITS + 1);
  localparam int POS_W      = 7;
  localparam int PROD_W     = 2 * VALUE_BITS;

  // floor(n / 10) == (n * DEC_RECIP) >> DEC_SHIFT for every 32-bit n.
  localparam logic [VALUE_BITS-1:0] DEC_RECIP = 32'hCCCC_CCCD;
  localparam int DEC_SHIFT = 35;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_t;

  typedef enum logic [1:0] {
    SIGN_NONE,
    SIGN_MINUS,
    SIGN_PLUS,
    SIGN_SPACE
  } sign_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIG,
    S_PLAN_A,
    S_PLAN_B,
    S_PLAN_C,
    S_PLAN_D,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic upper);
    logic [7:0] letter_base;
    letter_base = upper ? CH_UC_A : CH_LC_A;
    if (d < DIGIT_W'(10)) return CH_ZERO + 8'(d);
    return letter_base + 8'(d) - 8'd10;
  endfunction

  function automatic logic [7:0] sign_char(input sign_t s);
    logic [7:0] c;
    unique case (s)
      SIGN_MINUS: c = CH_MINUS;
      SIGN_PLUS:  c = CH_PLUS;
      SIGN_SPACE: c = CH_SPACE;
      SIGN_NONE:  c = CH_SPACE;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/itf_digit_unit.sv
// Shared digit extractor: one radix step (quotient and low digit) per use.
module itf_digit_unit (
  input  logic                            clk,
  input  logic                            load_prod,
  input  itf_pkg::radix_t                 radix,
  input  logic [itf_pkg::VALUE_BITS-1:0]  mag,
  output logic [itf_pkg::VALUE_BITS-1:0]  quot,
  output logic [itf_pkg::DIGIT_W-1:0]     digit
);

  logic [itf_pkg::PROD_W-1:0]     prod_r;
  logic [itf_pkg::VALUE_BITS-1:0] dec_q;
  logic [itf_pkg::VALUE_BITS-1:0] dec_q10;
  logic [itf_pkg::VALUE_BITS-1:0] dec_rem;

  // Reciprocal product for the decimal step; mag holds until the digit is taken.
  always_ff @(posedge clk) begin
    if (load_prod) begin
      prod_r <= itf_pkg::PROD_W'(mag) * itf_pkg::PROD_W'(itf_pkg::DEC_RECIP);
    end
  end

  assign dec_q   = itf_pkg::VALUE_BITS'(prod_r >> itf_pkg::DEC_SHIFT);
  assign dec_q10 = (dec_q << 3) + (dec_q << 1);
  assign dec_rem = mag - dec_q10;

  always_comb begin
    unique case (radix)
      itf_pkg::RADIX_BIN: begin
        quot  = mag >> 1;
        digit = itf_pkg::DIGIT_W'(mag[0]);
      end
      itf_pkg::RADIX_OCT: begin
        quot  = mag >> 3;
        digit = itf_pkg::DIGIT_W'(mag[2:0]);
      end
      itf_pkg::RADIX_DEC: begin
        quot  = dec_q;
        digit = dec_rem[itf_pkg::DIGIT_W-1:0];
      end
      itf_pkg::RADIX_HEX: begin
        quot  = mag >> 4;
        digit = mag[itf_pkg::DIGIT_W-1:0];
      end
    endcase
  end

endmodule

FILE: rtl/core/itf_digit_stack.sv
// Digit stack: digits go in least significant first and come out most significant first.
module itf_digit_stack (
  input  logic                         clk,
  input  itf_pkg::stack_ctl_t          ctl,
  input  logic [itf_pkg::DIGIT_W-1:0]  din,
  output logic [itf_pkg::DIGIT_W-1:0]  top
);

  logic [itf_pkg::DIGIT_W-1:0] stack_r [itf_pkg::MAX_DIGITS];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      stack_r[0] <= din;
      for (int i = 1; i < itf_pkg::MAX_DIGITS; i++) begin
        stack_r[i] <= stack_r[i-1];
      end
    end else if (ctl.pop) begin
      for (int i = 0; i < itf_pkg::MAX_DIGITS - 1; i++) begin
        stack_r[i] <= stack_r[i+1];
      end
      stack_r[itf_pkg::MAX_DIGITS-1] <= '0;
    end
  end

  assign top = stack_r[0];

endmodule

FILE: rtl/core/integer_to_text_formatter.sv
// Integer-to-text formatter top level: sequencer, field planning and character output.
// The shared digit unit yields one digit per cycle for binary, octal and hex; each decimal digit
// first passes through the S_MUL state, which loads the reciprocal product. Characters then
// leave one per cycle from the output register while out_ready does not stall them; an item
// yields at most 62 characters, and no new item is taken while one is being formatted.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties the output register.
module integer_to_text_formatter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [itf_pkg::VALUE_BITS-1:0] in_value,
  input  logic [1:0]                     in_radix_sel,
  input  logic                           in_is_signed,
  input  logic                           in_left_align,
  input  logic                           in_zero_pad,
  input  logic                           in_force_plus,
  input  logic                           in_space_sign,
  input  logic                           in_alt_form,
  input  logic                           in_upper_case,
  input  logic                           in_has_precision,
  input  logic [itf_pkg::FIELD_W-1:0]    in_field_width,
  input  logic [itf_pkg::FIELD_W-1:0]    in_min_digits,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_char,
  output logic                           out_last
);

  localparam int VB = itf_pkg::VALUE_BITS;
  localparam int FW = itf_pkg::FIELD_W;
  localparam int PW = itf_pkg::POS_W;
  localparam int NW = itf_pkg::NDIG_W;

  itf_pkg::state_t state_r, state_nxt;

  itf_pkg::radix_t radix_r, radix_nxt;
  itf_pkg::sign_t  sign_r, sign_nxt;
  logic            upper_r, upper_nxt;
  logic            left_r, left_nxt;
  logic            zpad_r, zpad_nxt;
  logic            alt_r, alt_nxt;
  logic            hasp_r, hasp_nxt;
  logic            val_zero_r, val_zero_nxt;
  logic [FW-1:0]   width_r, width_nxt;
  logic [FW-1:0]   prec_r, prec_nxt;
  logic [VB-1:0]   mag_r, mag_nxt;
  logic [NW-1:0]   nd_r, nd_nxt;
  logic [1:0]      npre_r, npre_nxt;
  logic [FW-1:0]   lz_r, lz_nxt;
  logic [FW-1:0]   pad_r, pad_nxt;
  logic [PW-1:0]   b1_r, b1_nxt;
  logic [PW-1:0]   b2_r, b2_nxt;
  logic [PW-1:0]   b3_r, b3_nxt;
  logic [PW-1:0]   b4_r, b4_nxt;
  logic [PW-1:0]   b5_r, b5_nxt;
  logic [PW-1:0]   total_r, total_nxt;
  logic [PW-1:0]   pos_r, pos_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_char_r, out_char_nxt;
  logic            out_last_r, out_last_nxt;

  // Accept-side decode
  itf_pkg::radix_t in_radix;
  logic            in_neg;
  logic [VB-1:0]   in_mag;
  itf_pkg::sign_t  in_sign;
  logic [FW-1:0]   in_width_sat;
  logic [FW-1:0]   in_prec_sat;

  // Planning arithmetic, all on registered values
  logic            has_sign;
  logic [PW-1:0]   sign_w, npre_w, nd_w, prec_w, width_w, lz_w, pad_w;
  logic            oct_skip_zero;
  logic [PW-1:0]   used_calc, lz_calc, len_calc, pad_calc;
  logic [PW-1:0]   b1_calc, b2_calc, b3_calc, b4_calc, b5_calc, total_calc;

  // Digit unit and stack
  logic                          load_prod;
  logic [VB-1:0]                 du_quot;
  logic [itf_pkg::DIGIT_W-1:0]   du_digit;
  itf_pkg::stack_ctl_t           stk_ctl;
  logic [itf_pkg::DIGIT_W-1:0]   stk_top;
  logic                          emit_go;

  itf_digit_unit u_digit (
    .clk       (clk),
    .load_prod (load_prod),
    .radix     (radix_r),
    .mag       (mag_r),
    .quot      (du_quot),
    .digit     (du_digit)
  );

  itf_digit_stack u_stack (
    .clk (clk),
    .ctl (stk_ctl),
    .din (du_digit),
    .top (stk_top)
  );

  always_comb begin
    in_radix     = itf_pkg::radix_t'(in_radix_sel);
    in_neg       = (in_radix == itf_pkg::RADIX_DEC) && in_is_signed && in_value[VB-1];
    in_mag       = in_neg ? (VB'(0) - in_value) : in_value;
    in_width_sat = (in_field_width > FW'(itf_pkg::MAX_FIELD)) ? FW'(itf_pkg::MAX_FIELD)
                                                              : in_field_width;
    in_prec_sat  = (in_min_digits > FW'(itf_pkg::MAX_FIELD)) ? FW'(itf_pkg::MAX_FIELD)
                                                             : in_min_digits;
    if (in_radix != itf_pkg::RADIX_DEC) in_sign = itf_pkg::SIGN_NONE;
    else if (in_neg)                    in_sign = itf_pkg::SIGN_MINUS;
    else if (in_force_plus)             in_sign = itf_pkg::SIGN_PLUS;
    else if (in_space_sign)             in_sign = itf_pkg::SIGN_SPACE;
    else                                in_sign = itf_pkg::SIGN_NONE;
  end

  always_comb begin
    has_sign = (sign_r != itf_pkg::SIGN_NONE);
    sign_w   = PW'(has_sign);
    npre_w   = PW'(npre_r);
    nd_w     = PW'(nd_r);
    prec_w   = PW'(prec_r);
    width_w  = PW'(width_r);
    lz_w     = PW'(lz_r);
    pad_w    = PW'(pad_r);

    // Octal alternate form drops its 0 when the digits already start with one.
    oct_skip_zero = (val_zero_r && (nd_r != '0)) || (hasp_r && (prec_w > nd_w));

    used_calc = sign_w + npre_w + nd_w;
    if (hasp_r) begin
      lz_calc = (prec_w > nd_w) ? (prec_w - nd_w) : '0;
    end else if (!left_r && zpad_r) begin
      lz_calc = (width_w > used_calc) ? (width_w - used_calc) : '0;
    end else begin
      lz_calc = '0;
    end

    len_calc = used_calc + lz_w;
    pad_calc = (width_w > len_calc) ? (width_w - len_calc) : '0;

    b1_calc    = left_r ? '0 : pad_w;
    b2_calc    = b1_calc + sign_w;
    b3_calc    = b2_calc + npre_w;
    b4_calc    = b3_calc + lz_w;
    b5_calc    = b4_calc + nd_w;
    total_calc = b5_calc + (left_r ? pad_w : '0);
  end

  assign emit_go = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    radix_nxt     = radix_r;
    sign_nxt      = sign_r;
    upper_nxt     = upper_r;
    left_nxt      = left_r;
    zpad_nxt      = zpad_r;
    alt_nxt       = alt_r;
    hasp_nxt      = hasp_r;
    val_zero_nxt  = val_zero_r;
    width_nxt     = width_r;
    prec_nxt      = prec_r;
    mag_nxt       = mag_r;
    nd_nxt        = nd_r;
    npre_nxt      = npre_r;
    lz_nxt        = lz_r;
    pad_nxt       = pad_r;
    b1_nxt        = b1_r;
    b2_nxt        = b2_r;
    b3_nxt        = b3_r;
    b4_nxt        = b4_r;
    b5_nxt        = b5_r;
    total_nxt     = total_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    load_prod     = 1'b0;
    stk_ctl       = '0;
    in_ready      = 1'b0;

    unique case (state_r)
      itf_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          radix_nxt    = in_radix;
          sign_nxt     = in_sign;
          upper_nxt    = in_upper_case;
          left_nxt     = in_left_align;
          zpad_nxt     = in_zero_pad;
          alt_nxt      = in_alt_form;
          hasp_nxt     = in_has_precision;
          val_zero_nxt = (in_value == '0);
          width_nxt    = in_width_sat;
          prec_nxt     = in_prec_sat;
          mag_nxt      = in_mag;
          nd_nxt       = '0;
          // Zero with a precision produces no digits at all.
          if ((in_mag != '0) || !in_has_precision) begin
            state_nxt = (in_radix == itf_pkg::RADIX_DEC) ? itf_pkg::S_MUL : itf_pkg::S_DIG;
          end else begin
            state_nxt = itf_pkg::S_PLAN_A;
          end
        end
      end

      itf_pkg::S_MUL: begin
        load_prod = 1'b1;
        state_nxt = itf_pkg::S_DIG;
      end

      itf_pkg::S_DIG: begin
        stk_ctl.push = 1'b1;
        mag_nxt      = du_quot;
        nd_nxt       = nd_r + NW'(1);
        if (du_quot == '0) begin
          state_nxt = itf_pkg::S_PLAN_A;
        end else begin
          state_nxt = (radix_r == itf_pkg::RADIX_DEC) ? itf_pkg::S_MUL : itf_pkg::S_DIG;
        end
      end

      itf_pkg::S_PLAN_A: begin
        npre_nxt = 2'd0;
        if (alt_r) begin
          if (radix_r == itf_pkg::RADIX_OCT && !oct_skip_zero) begin
            npre_nxt = 2'd1;
          end else if (radix_r == itf_pkg::RADIX_HEX && !val_zero_r) begin
            npre_nxt = 2'd2;
          end
        end
        state_nxt = itf_pkg::S_PLAN_B;
      end

      itf_pkg::S_PLAN_B: begin
        lz_nxt    = FW'(lz_calc);
        state_nxt = itf_pkg::S_PLAN_C;
      end

      itf_pkg::S_PLAN_C: begin
        pad_nxt   = FW'(pad_calc);
        state_nxt = itf_pkg::S_PLAN_D;
      end

      itf_pkg::S_PLAN_D: begin
        b1_nxt    = b1_calc;
        b2_nxt    = b2_calc;
        b3_nxt    = b3_calc;
        b4_nxt    = b4_calc;
        b5_nxt    = b5_calc;
        total_nxt = total_calc;
        pos_nxt   = '0;
        // Drop an item that formats to nothing.
        state_nxt = (total_calc == '0) ? itf_pkg::S_IDLE : itf_pkg::S_EMIT;
      end

      itf_pkg::S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = (pos_r == total_r - PW'(1));
          pos_nxt       = pos_r + PW'(1);
          if (pos_r < b1_r) begin
            out_char_nxt = itf_pkg::CH_SPACE;
          end else if (pos_r < b2_r) begin
            out_char_nxt = itf_pkg::sign_char(sign_r);
          end else if (pos_r < b3_r) begin
            if (pos_r == b2_r)  out_char_nxt = itf_pkg::CH_ZERO;
            else if (upper_r)   out_char_nxt = itf_pkg::CH_UC_X;
            else                out_char_nxt = itf_pkg::CH_LC_X;
          end else if (pos_r < b4_r) begin
            out_char_nxt = itf_pkg::CH_ZERO;
          end else if (pos_r < b5_r) begin
            out_char_nxt = itf_pkg::digit_char(stk_top, upper_r);
            stk_ctl.pop  = 1'b1;
          end else begin
            out_char_nxt = itf_pkg::CH_SPACE;
          end
          if (pos_r == total_r - PW'(1)) begin
            state_nxt = itf_pkg::S_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itf_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    radix_r    <= radix_nxt;
    sign_r     <= sign_nxt;
    upper_r    <= upper_nxt;
    left_r     <= left_nxt;
    zpad_r     <= zpad_nxt;
    alt_r      <= alt_nxt;
    hasp_r     <= hasp_nxt;
    val_zero_r <= val_zero_nxt;
    width_r    <= width_nxt;
    prec_r     <= prec_nxt;
    mag_r      <= mag_nxt;
    nd_r       <= nd_nxt;
    npre_r     <= npre_nxt;
    lz_r       <= lz_nxt;
    pad_r      <= pad_nxt;
    b1_r       <= b1_nxt;
    b2_r       <= b2_nxt;
    b3_r       <= b3_nxt;
    b4_r       <= b4_nxt;
    b5_r       <= b5_nxt;
    total_r    <= total_nxt;
    pos_r      <= pos_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

FILE: rtl/core/itf_checker.sv
// Port-level checker for the integer-to-text formatter, bound to the top level.
`include "integer_to_text_formatter_defines.svh"

module itf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);

  `ITF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(out_last), "output transaction changed while stalled")
  `ITF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken again right after a transaction")
  `ITF_ASSERT_NOW(a_busy_mid_number, out_valid && out_ready && !out_last, !in_ready, "input ready before the number is complete")
  `ITF_ASSERT_NOW(a_printable, out_valid, (out_char >= 8'h20) && (out_char <= 8'h7E), "non-printable character on output")

endmodule

bind integer_to_text_formatter itf_checker u_itf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_char  (out_char),
  .out_last  (out_last)
);

FILE: dv/tb_integer_to_text_formatter.sv
// Testbench for the integer-to-text formatter: random and directed numbers, checked per character.
module tb_integer_to_text_formatter;

  localparam int MAX_CHARS    = 64;
  localparam int RANDOM_ITEMS = 480;
  localparam int CALM_TAIL    = 60;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 3_000_000;

  // Conversion flag bits for make_req.
  localparam logic [7:0] F_SIGNED = 8'h80;
  localparam logic [7:0] F_LEFT   = 8'h40;
  localparam logic [7:0] F_ZPAD   = 8'h20;
  localparam logic [7:0] F_PLUS   = 8'h10;
  localparam logic [7:0] F_SPACE  = 8'h08;
  localparam logic [7:0] F_ALT    = 8'h04;
  localparam logic [7:0] F_UPPER  = 8'h02;
  localparam logic [7:0] F_PREC   = 8'h01;
  localparam logic [7:0] F_NONE   = 8'h00;

  typedef struct {
    logic [itf_pkg::VALUE_BITS-1:0] value;
    itf_pkg::radix_t                radix;
    logic                           is_signed;
    logic                           left_align;
    logic                           zero_pad;
    logic                           force_plus;
    logic                           space_sign;
    logic                           alt_form;
    logic                           upper_case;
    logic                           has_precision;
    logic [itf_pkg::FIELD_W-1:0]    field_width;
    logic [itf_pkg::FIELD_W-1:0]    min_digits;
  } fmt_req_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic [7:0] out_char;
  logic out_last;

  fmt_req_t   cur_req;
  fmt_req_t   pending[$];
  text_char_t expected_text[$];
  text_char_t want;

  logic in_fire = 1'b0;
  logic calm = 1'b0;
  logic hold_off = 1'b0;
  int   send_gap = 0;
  int   recv_stall = 0;
  int   items_taken = 0;
  int   mismatch_count = 0;
  int   cycles = 0;

  integer_to_text_formatter i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (cur_req.value),
    .in_radix_sel     (cur_req.radix),
    .in_is_signed     (cur_req.is_signed),
    .in_left_align    (cur_req.left_align),
    .in_zero_pad      (cur_req.zero_pad),
    .in_force_plus    (cur_req.force_plus),
    .in_space_sign    (cur_req.space_sign),
    .in_alt_form      (cur_req.alt_form),
    .in_upper_case    (cur_req.upper_case),
    .in_has_precision (cur_req.has_precision),
    .in_field_width   (cur_req.field_width),
    .in_min_digits    (cur_req.min_digits),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char         (out_char),
    .out_last         (out_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic fmt_req_t make_req(input logic [itf_pkg::VALUE_BITS-1:0] value,
                                        input itf_pkg::radix_t radix,
                                        input logic [7:0] flags, input int width, input int prec);
    fmt_req_t r;
    r.value         = value;
    r.radix         = radix;
    r.is_signed     = |(flags & F_SIGNED);
    r.left_align    = |(flags & F_LEFT);
    r.zero_pad      = |(flags & F_ZPAD);
    r.force_plus    = |(flags & F_PLUS);
    r.space_sign    = |(flags & F_SPACE);
    r.alt_form      = |(flags & F_ALT);
    r.upper_case    = |(flags & F_UPPER);
    r.has_precision = |(flags & F_PREC);
    r.field_width   = itf_pkg::FIELD_W'(width);
    r.min_digits    = itf_pkg::FIELD_W'(prec);
    return r;
  endfunction

  function automatic fmt_req_t random_req();
    logic [itf_pkg::VALUE_BITS-1:0] v;
    logic [7:0] flags;
    int width;
    int prec;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 20);
      2: v = 32'hFFFF_FFFF - $urandom_range(0, 20);
      3: v = 32'h1 << $urandom_range(0, 31);
      4: v = $urandom() >> $urandom_range(0, 31);
      default: v = {1'b1, 31'($urandom())};
    endcase
    flags = 8'($urandom());
    flags[0] = ($urandom_range(0, 2) == 0);
    width = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 16);
    prec  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
    return make_req(v, itf_pkg::radix_t'($urandom_range(0, 3)), flags, width, prec);
  endfunction

  // Build the character string of one number and queue it up.
  function automatic void predict_text(input fmt_req_t r);
    logic [itf_pkg::VALUE_BITS-1:0] mag;
    logic [4:0] base;
    logic [7:0] sign_ch;
    logic [7:0] digs[$];
    logic [7:0] pre[$];
    logic [7:0] text[$];
    logic zero_first;
    text_char_t c;
    int d, nd, lz, len, pad, width, prec, sign_len, n;
    mag = r.value;
    sign_ch = itf_pkg::CH_SPACE;
    sign_len = 0;
    lz = 0;
    width = (r.field_width > itf_pkg::MAX_FIELD) ? itf_pkg::MAX_FIELD : int'(r.field_width);
    prec  = (r.min_digits > itf_pkg::MAX_FIELD) ? itf_pkg::MAX_FIELD : int'(r.min_digits);
    case (r.radix)
      itf_pkg::RADIX_BIN: base = 5'd2;
      itf_pkg::RADIX_OCT: base = 5'd8;
      itf_pkg::RADIX_DEC: base = 5'd10;
      default:            base = 5'd16;
    endcase

    if (r.radix == itf_pkg::RADIX_DEC) begin
      if (r.is_signed && r.value[itf_pkg::VALUE_BITS-1]) begin
        sign_ch = itf_pkg::CH_MINUS;
        sign_len = 1;
        mag = '0 - r.value;
      end else if (r.force_plus) begin
        sign_ch = itf_pkg::CH_PLUS;
        sign_len = 1;
      end else if (r.space_sign) begin
        sign_ch = itf_pkg::CH_SPACE;
        sign_len = 1;
      end
    end

    // Zero with a precision shows no digits at all.
    if (mag != 0 || !r.has_precision) begin
      do begin
        d = int'(mag % base);
        digs.push_front((d < 10) ? 8'(itf_pkg::CH_ZERO + d)
                                 : 8'((r.upper_case ? itf_pkg::CH_UC_A
                                                    : itf_pkg::CH_LC_A) + d - 10));
        mag = mag / base;
      end while (mag != 0);
    end
    nd = digs.size();

    if (r.alt_form) begin
      if (r.radix == itf_pkg::RADIX_OCT) begin
        zero_first = (r.value == 0) && (nd != 0);
        if (r.has_precision && prec > nd) zero_first = 1'b1;
        if (!zero_first) pre.push_back(itf_pkg::CH_ZERO);
      end else if (r.radix == itf_pkg::RADIX_HEX && r.value != 0) begin
        pre.push_back(itf_pkg::CH_ZERO);
        pre.push_back(r.upper_case ? itf_pkg::CH_UC_X : itf_pkg::CH_LC_X);
      end
    end

    if (r.has_precision) lz = prec - nd;
    else if (!r.left_align && r.zero_pad) lz = width - sign_len - pre.size() - nd;
    if (lz < 0) lz = 0;
    len = sign_len + pre.size() + lz + nd;
    pad = (width > len) ? width - len : 0;

    if (!r.left_align) repeat (pad) text.push_back(itf_pkg::CH_SPACE);
    if (sign_len != 0) text.push_back(sign_ch);
    foreach (pre[i]) text.push_back(pre[i]);
    repeat (lz) text.push_back(itf_pkg::CH_ZERO);
    foreach (digs[i]) text.push_back(digs[i]);
    if (r.left_align) repeat (pad) text.push_back(itf_pkg::CH_SPACE);

    n = (text.size() > MAX_CHARS) ? MAX_CHARS : text.size();
    for (int i = 0; i < n; i++) begin
      c.ch = text[i];
      c.last = (i == n - 1);
      expected_text.push_back(c);
    end
  endfunction

  // Sender: hold the payload until the transaction completes, then maybe idle.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_fire)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (!calm && !hold_off && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(1, 18) - 1;
        in_valid <= 1'b0;
      end else if (pending.size() > 0) begin
        cur_req <= pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus the long hold-off.
  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      recv_stall = $urandom_range(1, 18) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Let the output back up long enough to stall the input side.
  initial begin
    wait (items_taken >= 40);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    in_fire <= in_valid && in_ready;
    calm <= (pending.size() < CALM_TAIL);
    if (rst_n && in_valid && in_ready) begin
      predict_text(cur_req);
      items_taken++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected char: expected none, actual char %h last %b",
                 $time, out_char, out_last);
        mismatch_count++;
      end else begin
        want = expected_text.pop_front();
        if (out_char !== want.ch) begin
          $display("%0t: out_char mismatch: expected %h, actual %h", $time, want.ch, out_char);
          mismatch_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: out_last mismatch: expected %b, actual %b", $time, want.last, out_last);
          mismatch_count++;
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    cur_req = make_req('0, itf_pkg::RADIX_BIN, F_NONE, 0, 0);

    pending.push_back(make_req(32'd0, itf_pkg::RADIX_DEC, F_NONE, 0, 0));
    pending.push_back(make_req(32'd0, itf_pkg::RADIX_DEC, F_PREC, 0, 0));
    pending.push_back(make_req(32'd0, itf_pkg::RADIX_HEX, F_PREC | F_ALT, 5, 0));
    pending.push_back(make_req(32'd0, itf_pkg::RADIX_DEC, F_PREC | F_PLUS, 0, 0));
    pending.push_back(make_req(32'h8000_0000, itf_pkg::RADIX_DEC, F_SIGNED, 0, 0));
    pending.push_back(make_req(32'hFFFF_FFFF, itf_pkg::RADIX_DEC, F_NONE, 0, 0));
    pending.push_back(make_req(32'hFFFF_FFFF, itf_pkg::RADIX_BIN, F_NONE, 0, 0));
    pending.push_back(make_req(32'hFFFF_FFFF, itf_pkg::RADIX_OCT, F_ALT, 0, 0));
    pending.push_back(make_req(32'd0, itf_pkg::RADIX_OCT, F_ALT, 0, 0));
    pending.push_back(make_req(32'd0, itf_pkg::RADIX_OCT, F_ALT | F_PREC, 0, 0));
    pending.push_back(make_req(32'd8, itf_pkg::RADIX_OCT, F_ALT | F_PREC, 0, 5));
    pending.push_back(make_req(32'd0, itf_pkg::RADIX_HEX, F_ALT, 0, 0));
    pending.push_back(make_req(32'hDEAD_BEEF, itf_pkg::RADIX_HEX, F_ALT | F_UPPER, 0, 0));
    pending.push_back(make_req(32'hDEAD_BEEF, itf_pkg::RADIX_HEX, F_ALT | F_ZPAD, 14, 0));
    pending.push_back(make_req(32'd5, itf_pkg::RADIX_DEC, F_PLUS | F_SPACE, 0, 0));
    pending.push_back(make_req(32'd5, itf_pkg::RADIX_DEC, F_SIGNED | F_SPACE, 3, 0));
    pending.push_back(make_req(32'hFFFF_FFFF, itf_pkg::RADIX_DEC, F_SIGNED | F_ZPAD, 10, 0));
    pending.push_back(make_req(32'hFFFF_FFFF, itf_pkg::RADIX_HEX,
                               F_SIGNED | F_PLUS | F_SPACE, 0, 0));
    pending.push_back(make_req(32'd1234, itf_pkg::RADIX_DEC, F_LEFT | F_ZPAD | F_PLUS, 20, 0));
    pending.push_back(make_req(32'd1234, itf_pkg::RADIX_DEC, F_ZPAD | F_PREC, 12, 6));
    pending.push_back(make_req(32'hFFFF_FFFF, itf_pkg::RADIX_HEX,
                               F_ALT | F_PREC | F_UPPER, 63, 63));
    pending.push_back(make_req(32'h7FFF_FFFF, itf_pkg::RADIX_DEC,
                               F_SIGNED | F_PLUS | F_PREC, 61, 62));
    pending.push_back(make_req(32'hFFFF_FFFF, itf_pkg::RADIX_BIN, F_LEFT, 60, 0));
    pending.push_back(make_req(32'd0, itf_pkg::RADIX_BIN, F_ZPAD | F_SPACE, 63, 0));
    for (int i = 0; i < RANDOM_ITEMS; i++) pending.push_back(random_req());

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (pending.size() > 0 || in_valid || expected_text.size() > 0) @(posedge clk);
    // Items that print nothing may still be in flight.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_text.size() > 0) begin
      $display("%0t: %0d expected chars never arrived", $time, expected_text.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
